>>> rtl/core/tsgc_pkg.sv
`timescale 1ns / 1ps

package tsgc_pkg;

    localparam int TICK_W     = 32;
    localparam int BW_W       = 12;
    localparam int CT_W       = 16;
    localparam int SD_W       = 12;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int BIN_W      = 4;
    localparam int CNT_W      = 16;
    localparam int N_CNT      = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_BIN_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLICK_MAX = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWIPE_MIN = 2'd2;

    localparam logic [BW_W-1:0] BIN_WIDTH_RST = 12'd455;
    localparam logic [CT_W-1:0] CLICK_MAX_RST = 16'd250;
    localparam logic [SD_W-1:0] SWIPE_MIN_RST = 12'd1024;

    localparam logic [BIN_W-1:0] BIN_MAX   = 4'd15;
    localparam logic [BIN_W-1:0] DEAD_LOW  = 4'd4;
    localparam logic [BIN_W-1:0] DEAD_HIGH = 4'd5;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    // hit counter slots
    localparam int C_B1    = 0;
    localparam int C_B2    = 1;
    localparam int C_X     = 2;
    localparam int C_Y     = 3;
    localparam int C_MAGIC = 4;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SCROLL = 2'd1;
    localparam logic [1:0] EV_CLICK  = 2'd2;

    localparam logic [2:0] CK_MAGIC     = 3'd0;
    localparam logic [2:0] CK_SWIPE_DEC = 3'd1;
    localparam logic [2:0] CK_SWIPE_INC = 3'd2;
    localparam logic [2:0] CK_BTN_ONE   = 3'd3;
    localparam logic [2:0] CK_BTN_TWO   = 3'd4;
    localparam logic [2:0] CK_TAP       = 3'd5;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

>>> rtl/core/touch_slider_gesture_classifier_unit.sv
`timescale 1ns / 1ps

// touch slider gesture classifier
// input channel in_valid/in_ready carries one slider sample per item: button
// flags, slider touch flags, x/y positions and the current tick
// output channel out_valid/out_ready returns exactly one result item per input
// item: event_kind, scroll_delta and click_kind, all zero when nothing happened
// configuration: cfg_we writes cfg_wdata into register cfg_addr (0 bin width,
// 1 click max ticks, 2 swipe min dx) with no wait; write only while idle
// timing: the y bin comes from a restoring divider that makes one quotient bit
// per cycle over max(POS_BITS,12)+1 bits (13 by default); out_valid rises when
// the result is committed into the output register, and the next item
// is taken once the result is registered, so items are handled one at a time
// a stalled receiver holds the result in the output register; the block still
// finishes the next item and then waits until the register frees up
// reset clears all touch state, restores the configuration defaults and
// leaves both channels empty
module touch_slider_gesture_classifier_unit #(
    parameter int HISTORY_DEPTH = 3,
    parameter int POS_BITS      = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsgc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tsgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            btn_one,
    input  logic                            btn_two,
    input  logic                            y_touch,
    input  logic                            x_touch,
    input  logic [POS_BITS-1:0]             x_pos,
    input  logic [POS_BITS-1:0]             y_pos,
    input  logic [tsgc_pkg::TICK_W-1:0]     now_tick,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      event_kind,
    output logic signed [4:0]               scroll_delta,
    output logic [2:0]                      click_kind
);
    import tsgc_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    tsgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    tsgc_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .POS_BITS      (POS_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .btn_one      (btn_one),
        .btn_two      (btn_two),
        .y_touch      (y_touch),
        .x_touch      (x_touch),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .now_tick     (now_tick),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .event_kind   (event_kind),
        .scroll_delta (scroll_delta),
        .click_kind   (click_kind)
    );

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |-> (!out_valid || out_ready))
        else $error("result committed over an untaken item");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> out_valid)
        else $error("committed result not presented");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in work");

    a_delta_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind != EV_SCROLL)) |-> (scroll_delta == '0))
        else $error("scroll delta set on a non-scroll item");
`endif

endmodule

>>> rtl/core/tsgc_ctrl.sv
`timescale 1ns / 1ps

module tsgc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tsgc_pkg::dp_cmd_t    cmd,
    input  tsgc_pkg::dp_status_t status
);
    import tsgc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit;

    // result may go out only when the output register is free or being emptied
    assign commit = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.step   = (state_reg == ST_DIV);
    assign cmd.commit = commit;

endmodule

>>> rtl/core/tsgc_dp.sv
`timescale 1ns / 1ps

module tsgc_dp #(
    parameter int HISTORY_DEPTH = 3,
    parameter int POS_BITS      = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tsgc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [tsgc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  btn_one,
    input  logic                                  btn_two,
    input  logic                                  y_touch,
    input  logic                                  x_touch,
    input  logic [POS_BITS-1:0]                   x_pos,
    input  logic [POS_BITS-1:0]                   y_pos,
    input  logic [tsgc_pkg::TICK_W-1:0]           now_tick,
    input  tsgc_pkg::dp_cmd_t                     cmd,
    output tsgc_pkg::dp_status_t                  status,
    output logic [1:0]                            event_kind,
    output logic signed [4:0]                     scroll_delta,
    output logic [2:0]                            click_kind
);
    import tsgc_pkg::*;

    localparam int NUM_W  = ((POS_BITS > BW_W) ? POS_BITS : BW_W) + 1;
    localparam int DX_W   = NUM_W - 1;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic in_dead(input logic [BIN_W-1:0] b);
        in_dead = (b >= DEAD_LOW) && (b <= DEAD_HIGH);
    endfunction

    // configuration
    logic [BW_W-1:0] bin_width_reg;
    logic [CT_W-1:0] click_max_reg;
    logic [SD_W-1:0] swipe_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= BIN_WIDTH_RST;
            click_max_reg <= CLICK_MAX_RST;
            swipe_min_reg <= SWIPE_MIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BIN_WIDTH: bin_width_reg <= cfg_wdata[BW_W-1:0];
                CFG_CLICK_MAX: click_max_reg <= cfg_wdata[CT_W-1:0];
                CFG_SWIPE_MIN: swipe_min_reg <= cfg_wdata[SD_W-1:0];
                default: ;
            endcase
        end
    end

    // item latch
    logic                b1_reg, b2_reg, yt_reg, xt_reg;
    logic [POS_BITS-1:0] xpos_reg;
    logic [TICK_W-1:0]   now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            b1_reg   <= btn_one;
            b2_reg   <= btn_two;
            yt_reg   <= y_touch;
            xt_reg   <= x_touch;
            xpos_reg <= x_pos;
            now_reg  <= now_tick;
        end
    end

    // restoring divider, one quotient bit per cycle; num_reg ends as the quotient
    logic [NUM_W-1:0]  num_reg;
    logic [BW_W-1:0]   rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [BW_W:0]     rem_sh;
    logic              rem_ge;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, bin_width_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg <= NUM_W'(y_pos) + NUM_W'(bin_width_reg[BW_W-1:1]);
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? BW_W'(rem_sh - {1'b0, bin_width_reg}) : rem_sh[BW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
        end
        else if (cmd.step)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    assign status.div_done = cmd.step && (step_reg == STEP_LAST);

    logic [BIN_W-1:0] q;
    assign q = ((bin_width_reg == '0) || (num_reg > NUM_W'(BIN_MAX))) ? BIN_MAX
                                                                     : num_reg[BIN_W-1:0];

    // gesture state
    logic                touch_active_reg, touch_active_next;
    logic [TICK_W-1:0]   tdt_reg, tdt_next;
    logic [CNT_W-1:0]    cnt_reg [N_CNT];
    logic [CNT_W-1:0]    cnt_next [N_CNT];
    logic                xs_vld_reg, xs_vld_next;
    logic [POS_BITS-1:0] xs_val_reg, xs_val_next;
    logic [POS_BITS-1:0] x_last_reg, x_last_next;
    logic                ysb_vld_reg, ysb_vld_next;
    logic [BIN_W-1:0]    ysb_val_reg, ysb_val_next;
    logic                sb_vld_reg, sb_vld_next;
    logic [BIN_W-1:0]    sb_val_reg, sb_val_next;
    logic                hist_vld_reg [HISTORY_DEPTH];
    logic                hist_vld_next [HISTORY_DEPTH];
    logic [BIN_W-1:0]    hist_val_reg [HISTORY_DEPTH];
    logic [BIN_W-1:0]    hist_val_next [HISTORY_DEPTH];
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                emitted_reg, emitted_next;

    logic touching;
    assign touching = b1_reg || b2_reg || yt_reg || xt_reg;

    // figures that settle while the divider runs; their sources hold until commit
    logic [TICK_W-1:0]   dt_reg;
    logic                dt_gt_reg, dt_lt_reg;
    logic [CNT_W-1:0]    m01_reg, m23_reg, mx_reg;
    logic                swipe_reg, x_gt_reg;
    logic [POS_BITS-1:0] abs_dx;

    assign abs_dx = (xs_val_reg > x_last_reg) ? xs_val_reg - x_last_reg
                                              : x_last_reg - xs_val_reg;

    always_ff @(posedge clk)
    begin
        dt_reg    <= (!touch_active_reg && touching) ? '0 : now_reg - tdt_reg;
        dt_gt_reg <= dt_reg > TICK_W'(click_max_reg);
        dt_lt_reg <= dt_reg < TICK_W'(click_max_reg);
        m01_reg   <= (cnt_reg[C_B1] > cnt_reg[C_B2]) ? cnt_reg[C_B1] : cnt_reg[C_B2];
        m23_reg   <= (cnt_reg[C_X] > cnt_reg[C_Y]) ? cnt_reg[C_X] : cnt_reg[C_Y];
        mx_reg    <= (m01_reg > m23_reg) ? m01_reg : m23_reg;
        swipe_reg <= (cnt_reg[C_X] != '0) && xs_vld_reg &&
                     (DX_W'(abs_dx) >= DX_W'(swipe_min_reg));
        x_gt_reg  <= xs_val_reg > x_last_reg;
    end

    logic all_match;
    always_comb
    begin
        all_match = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if ((SLOT_W'(i) != slot_reg) && !(hist_vld_reg[i] && (hist_val_reg[i] == q)))
            begin
                all_match = 1'b0;
            end
        end
    end

    logic [1:0] kind_n;
    logic [4:0] delta_n;
    logic [2:0] ck_n;

    always_comb
    begin
        logic [BIN_W-1:0] ysb_cand;
        logic             dead;
        logic             far;
        logic             magic_nz;

        touch_active_next = touch_active_reg;
        tdt_next          = tdt_reg;
        xs_vld_next       = xs_vld_reg;
        xs_val_next       = xs_val_reg;
        x_last_next       = x_last_reg;
        ysb_vld_next      = ysb_vld_reg;
        ysb_val_next      = ysb_val_reg;
        sb_vld_next       = sb_vld_reg;
        sb_val_next       = sb_val_reg;
        slot_next         = slot_reg;
        emitted_next      = emitted_reg;
        for (int i = 0; i < N_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            hist_vld_next[i] = hist_vld_reg[i];
            hist_val_next[i] = hist_val_reg[i];
        end
        kind_n   = EV_NONE;
        delta_n  = '0;
        ck_n     = CK_MAGIC;
        ysb_cand = ysb_vld_reg ? ysb_val_reg : q;
        dead     = !emitted_reg && in_dead(ysb_cand) && in_dead(q);
        far      = (sb_val_reg > q) ? ((sb_val_reg - q) > 4'd1) : ((q - sb_val_reg) > 4'd1);
        magic_nz = cnt_reg[C_MAGIC] != '0;

        if (!touch_active_reg && touching)
        begin
            tdt_next          = now_reg;
            touch_active_next = 1'b1;
        end

        if (touching)
        begin
            if (xt_reg)
            begin
                cnt_next[C_X] = sat_inc(cnt_reg[C_X]);
                if (!xs_vld_reg)
                begin
                    xs_vld_next = 1'b1;
                    xs_val_next = xpos_reg;
                end
                x_last_next = xpos_reg;
            end
            if (yt_reg)
            begin
                cnt_next[C_Y]           = sat_inc(cnt_reg[C_Y]);
                hist_vld_next[slot_reg] = 1'b1;
                hist_val_next[slot_reg] = q;
                slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                // bin is stable and differs from the scroll position, if one is held
                if (all_match && !(sb_vld_reg && (sb_val_reg == q)))
                begin
                    if (dead)
                    begin
                        ysb_vld_next = 1'b0;
                    end
                    else
                    begin
                        ysb_vld_next = 1'b1;
                        ysb_val_next = ysb_cand;
                        if (dt_gt_reg || (sb_vld_reg && far))
                        begin
                            if (sb_vld_reg)
                            begin
                                kind_n       = EV_SCROLL;
                                delta_n      = {1'b0, q} - {1'b0, sb_val_reg};
                                emitted_next = 1'b1;
                            end
                            sb_vld_next = 1'b1;
                            sb_val_next = q;
                        end
                    end
                end
            end
            else if (b1_reg)
            begin
                cnt_next[C_B1] = sat_inc(cnt_reg[C_B1]);
            end
            else if (b2_reg)
            begin
                cnt_next[C_B2] = sat_inc(cnt_reg[C_B2]);
            end
            if (b1_reg && b2_reg)
            begin
                cnt_next[C_MAGIC] = sat_inc(cnt_reg[C_MAGIC]);
            end
        end

        // release: classify, then drop all touch state
        if (touch_active_reg && !touching)
        begin
            if (dt_lt_reg || magic_nz || swipe_reg)
            begin
                priority if (magic_nz)
                begin
                    kind_n = EV_CLICK;
                    ck_n   = CK_MAGIC;
                end
                else if (swipe_reg)
                begin
                    kind_n = EV_CLICK;
                    ck_n   = x_gt_reg ? CK_SWIPE_DEC : CK_SWIPE_INC;
                end
                else if (cnt_reg[C_B1] == mx_reg)
                begin
                    kind_n = EV_CLICK;
                    ck_n   = CK_BTN_ONE;
                end
                else if (cnt_reg[C_B2] == mx_reg)
                begin
                    kind_n = EV_CLICK;
                    ck_n   = CK_BTN_TWO;
                end
                else if ((cnt_reg[C_Y] == mx_reg) && !emitted_reg)
                begin
                    kind_n = EV_CLICK;
                    ck_n   = CK_TAP;
                end
            end
            touch_active_next = 1'b0;
            emitted_next      = 1'b0;
            xs_vld_next       = 1'b0;
            ysb_vld_next      = 1'b0;
            sb_vld_next       = 1'b0;
            for (int i = 0; i < N_CNT; i++)
            begin
                cnt_next[i] = '0;
            end
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_vld_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_active_reg <= 1'b0;
            tdt_reg          <= '0;
            xs_vld_reg       <= 1'b0;
            xs_val_reg       <= '0;
            x_last_reg       <= '0;
            ysb_vld_reg      <= 1'b0;
            ysb_val_reg      <= '0;
            sb_vld_reg       <= 1'b0;
            sb_val_reg       <= '0;
            slot_reg         <= '0;
            emitted_reg      <= 1'b0;
            for (int i = 0; i < N_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_vld_reg[i] <= 1'b0;
                hist_val_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            touch_active_reg <= touch_active_next;
            tdt_reg          <= tdt_next;
            xs_vld_reg       <= xs_vld_next;
            xs_val_reg       <= xs_val_next;
            x_last_reg       <= x_last_next;
            ysb_vld_reg      <= ysb_vld_next;
            ysb_val_reg      <= ysb_val_next;
            sb_vld_reg       <= sb_vld_next;
            sb_val_reg       <= sb_val_next;
            slot_reg         <= slot_next;
            emitted_reg      <= emitted_next;
            for (int i = 0; i < N_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_vld_reg[i] <= hist_vld_next[i];
                hist_val_reg[i] <= hist_val_next[i];
            end
        end
    end

    // output register
    logic [1:0] kind_reg;
    logic [4:0] delta_reg;
    logic [2:0] ck_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            kind_reg  <= kind_n;
            delta_reg <= delta_n;
            ck_reg    <= ck_n;
        end
    end

    assign event_kind   = kind_reg;
    assign scroll_delta = signed'(delta_reg);
    assign click_kind   = ck_reg;

endmodule

>>> sim/tb_touch_slider_gesture_classifier_unit.sv
`timescale 1ns / 1ps

module tb_touch_slider_gesture_classifier_unit;

    import tsgc_pkg::*;

    localparam int POS_W = 12;

    typedef struct packed {
        logic             btn_one;
        logic             btn_two;
        logic             y_touch;
        logic             x_touch;
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic [31:0]      now_tick;
    } slider_sample_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] delta;
        logic [2:0] click;
    } gesture_event_t;

    class gesture_scoreboard;
        logic [BW_W-1:0]  bin_width;
        logic [CT_W-1:0]  click_max;
        logic [SD_W-1:0]  swipe_min;
        bit               touch_active;
        logic [31:0]      touchdown_tick;
        logic [CNT_W-1:0] hits [N_CNT];
        int               x_start;
        int               x_last;
        int               y_start_bin;
        int               scroll_bin;
        int               bin_hist [3];
        int               hist_slot;
        bit               scroll_emitted;
        gesture_event_t   expected_events [$];
        int               mismatches;

        function new();
            bin_width      = BIN_WIDTH_RST;
            click_max      = CLICK_MAX_RST;
            swipe_min      = SWIPE_MIN_RST;
            touchdown_tick = '0;
            x_last         = 0;
            hist_slot      = 0;
            mismatches     = 0;
            end_touch();
        endfunction

        function void end_touch();
            touch_active   = 0;
            scroll_emitted = 0;
            x_start        = -1;
            y_start_bin    = -1;
            scroll_bin     = -1;
            foreach (hits[i])
                hits[i] = '0;
            foreach (bin_hist[i])
                bin_hist[i] = -1;
        endfunction

        function void bump(int k);
            if (hits[k] != CNT_MAX)
                hits[k]++;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BIN_WIDTH: bin_width = val[BW_W-1:0];
                CFG_CLICK_MAX: click_max = val[CT_W-1:0];
                CFG_SWIPE_MIN: swipe_min = val[SD_W-1:0];
                default: ;
            endcase
        endfunction

        // predicts the result item of one accepted sample
        function void classify_sample(slider_sample_t s);
            bit             touching;
            bit             dead;
            bit             swipe;
            logic [31:0]    dt;
            int             y;
            int             bw;
            int             q;
            int             pos;
            int             span;
            int             mx;
            gesture_event_t ev;
            ev = '0;
            touching = s.btn_one | s.btn_two | s.y_touch | s.x_touch;
            if (!touch_active && touching)
            begin
                touchdown_tick = s.now_tick;
                touch_active   = 1;
            end
            dt = s.now_tick - touchdown_tick;

            if (touch_active)
            begin
                if (s.x_touch)
                begin
                    bump(C_X);
                    if (x_start == -1)
                        x_start = int'(s.x_pos);
                    x_last = int'(s.x_pos);
                end
                if (s.y_touch)
                begin
                    bump(C_Y);
                    y  = int'(s.y_pos);
                    bw = int'(bin_width);
                    if (bw == 0)
                        q = int'(BIN_MAX);
                    else
                        q = (y + bw / 2) / bw;
                    if (q > int'(BIN_MAX))
                        q = int'(BIN_MAX);
                    pos = q;
                    if (hist_slot >= 3)
                        hist_slot = 0;
                    bin_hist[hist_slot] = q;
                    hist_slot = (hist_slot + 1) % 3;
                    // bin only passes once the whole history agrees
                    foreach (bin_hist[i])
                        if (bin_hist[i] != q)
                            pos = scroll_bin;

                    if (pos != scroll_bin && pos != -1)
                    begin
                        if (y_start_bin == -1)
                            y_start_bin = pos;
                        dead = !scroll_emitted && y_start_bin >= int'(DEAD_LOW) &&
                               y_start_bin <= int'(DEAD_HIGH);
                        if (dead && (pos < int'(DEAD_LOW) || pos > int'(DEAD_HIGH)))
                            dead = 0;
                        span = scroll_bin - pos;
                        if (span < 0)
                            span = -span;
                        if (dead)
                            y_start_bin = -1;
                        else if (dt > 32'(click_max) || (scroll_bin != -1 && span > 1))
                        begin
                            if (scroll_bin != -1)
                            begin
                                ev.kind        = EV_SCROLL;
                                ev.delta       = 5'(pos - scroll_bin);
                                scroll_emitted = 1;
                            end
                            scroll_bin = pos;
                        end
                    end
                end
                else if (s.btn_one)
                    bump(C_B1);
                else if (s.btn_two)
                    bump(C_B2);
                if (s.btn_one && s.btn_two)
                    bump(C_MAGIC);
            end

            if (touch_active && !touching)
            begin
                span = x_start - x_last;
                if (span < 0)
                    span = -span;
                swipe = hits[C_X] != 0 && x_start != -1 && span >= int'(swipe_min);
                if (dt < 32'(click_max) || hits[C_MAGIC] != 0 || swipe)
                begin
                    mx = 0;
                    foreach (hits[i])
                        if (int'(hits[i]) > mx)
                            mx = int'(hits[i]);
                    if (hits[C_MAGIC] != 0)
                    begin
                        ev.kind  = EV_CLICK;
                        ev.click = CK_MAGIC;
                    end
                    else if (swipe)
                    begin
                        ev.kind  = EV_CLICK;
                        ev.click = (x_start > x_last) ? CK_SWIPE_DEC : CK_SWIPE_INC;
                    end
                    else if (int'(hits[C_B1]) == mx)
                    begin
                        ev.kind  = EV_CLICK;
                        ev.click = CK_BTN_ONE;
                    end
                    else if (int'(hits[C_B2]) == mx)
                    begin
                        ev.kind  = EV_CLICK;
                        ev.click = CK_BTN_TWO;
                    end
                    else if (int'(hits[C_Y]) == mx && !scroll_emitted)
                    begin
                        ev.kind  = EV_CLICK;
                        ev.click = CK_TAP;
                    end
                end
                end_touch();
            end
            expected_events.push_back(ev);
        endfunction

        function void check_event(logic [1:0] kind, logic [4:0] delta, logic [2:0] click);
            gesture_event_t want;
            if (expected_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: kind %0d delta %0d click %0d",
                             kind, $signed(delta), click);
            end
            else
            begin
                want = expected_events.pop_front();
                if (want.kind !== kind || want.delta !== delta || want.click !== click)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d delta %0d click %0d, got kind %0d delta %0d click %0d",
                                 want.kind, $signed(want.delta), want.click,
                                 kind, $signed(delta), click);
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  btn_one   = 1'b0;
    logic                  btn_two   = 1'b0;
    logic                  y_touch   = 1'b0;
    logic                  x_touch   = 1'b0;
    logic [POS_W-1:0]      x_pos     = '0;
    logic [POS_W-1:0]      y_pos     = '0;
    logic [TICK_W-1:0]     now_tick  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            event_kind;
    logic signed [4:0]     scroll_delta;
    logic [2:0]            click_kind;

    gesture_scoreboard sb;
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                items_sent = 0;
    logic [31:0]       cur_tick = '0;

    touch_slider_gesture_classifier_unit #(
        .HISTORY_DEPTH (3),
        .POS_BITS      (POS_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .btn_one      (btn_one),
        .btn_two      (btn_two),
        .y_touch      (y_touch),
        .x_touch      (x_touch),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .now_tick     (now_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .scroll_delta (scroll_delta),
        .click_kind   (click_kind)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_event(event_kind, scroll_delta, click_kind);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(input logic b1, input logic b2, input logic yt, input logic xt,
                               input logic [POS_W-1:0] xp, input logic [POS_W-1:0] yp,
                               input logic [31:0] tk);
        slider_sample_t s;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        btn_one  <= b1;
        btn_two  <= b2;
        y_touch  <= yt;
        x_touch  <= xt;
        x_pos    <= xp;
        y_pos    <= yp;
        now_tick <= tk;
        do
            @(posedge clk);
        while (!in_ready);
        s = '{btn_one: b1, btn_two: b2, y_touch: yt, x_touch: xt,
              x_pos: xp, y_pos: yp, now_tick: tk};
        sb.classify_sample(s);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic advance_tick();
        if ($urandom_range(0, 9) == 0)
            cur_tick = cur_tick + $urandom_range(0, 3000);
        else
            cur_tick = cur_tick + $urandom_range(0, 60);
    endtask

    // one touch from touchdown to release, mostly well formed
    task automatic run_gesture();
        int shape;
        int n;
        int i;
        int j;
        int h;
        int hold;
        int y;
        int step;
        int xs;
        int xe;
        if ($urandom_range(0, 5) == 0)
            cur_tick = 32'hFFFF_FFFF - $urandom_range(0, 400);
        else
            cur_tick = $urandom;
        shape = $urandom_range(0, 9);
        n     = $urandom_range(1, 6);
        case (shape)
            0, 1:
            begin
                for (i = 0; i < n; i++)
                begin
                    send_sample(shape == 0, shape == 1, 1'b0, 1'b0, POS_W'($urandom),
                                POS_W'($urandom), cur_tick);
                    advance_tick();
                end
            end
            2:
            begin
                for (i = 0; i < n; i++)
                begin
                    send_sample(1'b1, $urandom_range(0, 3) != 0, 1'b0, 1'b0,
                                POS_W'($urandom), POS_W'($urandom), cur_tick);
                    advance_tick();
                end
            end
            3, 4:
            begin
                n  = $urandom_range(2, 6);
                xs = $urandom_range(0, 4095);
                xe = $urandom_range(0, 4095);
                for (i = 0; i < n; i++)
                begin
                    send_sample($urandom_range(0, 7) == 0, 1'b0, 1'b0, 1'b1,
                                POS_W'(xs + (xe - xs) * i / (n - 1)), POS_W'($urandom),
                                cur_tick);
                    advance_tick();
                end
            end
            5, 6:
            begin
                y = $urandom_range(0, 4095);
                for (j = 0; j < n; j++)
                begin
                    // two samples at one position fall short of the history filter
                    hold = $urandom_range(2, 5);
                    for (h = 0; h < hold; h++)
                    begin
                        send_sample(1'b0, 1'b0, 1'b1, $urandom_range(0, 5) == 0,
                                    POS_W'($urandom), POS_W'(y), cur_tick);
                        advance_tick();
                    end
                    if (sb.bin_width == 0)
                        y = $urandom_range(0, 4095);
                    else
                    begin
                        step = sb.bin_width * $urandom_range(0, 2) +
                               $urandom_range(0, sb.bin_width / 4);
                        if ($urandom_range(0, 1) == 0)
                            y = y + step;
                        else
                            y = y - step;
                        if (y < 0)
                            y = 0;
                        if (y > 4095)
                            y = 4095;
                    end
                end
            end
            7:
            begin
                y = $urandom_range(0, 4095);
                for (i = 0; i < n; i++)
                begin
                    send_sample(1'b0, 1'b0, 1'b1, 1'b0, POS_W'($urandom), POS_W'(y), cur_tick);
                    advance_tick();
                end
            end
            default:
            begin
                for (i = 0; i < n; i++)
                begin
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                POS_W'($urandom), POS_W'($urandom), cur_tick);
                    advance_tick();
                end
            end
        endcase
        advance_tick();
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, POS_W'($urandom), POS_W'($urandom), cur_tick);
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [BW_W-1:0] bw,
                             input logic [CT_W-1:0] cm, input logic [SD_W-1:0] sd,
                             input int count);
        int stop;
        write_reg(CFG_BIN_WIDTH, CFG_DATA_W'(bw));
        write_reg(CFG_CLICK_MAX, CFG_DATA_W'(cm));
        write_reg(CFG_SWIPE_MIN, CFG_DATA_W'(sd));
        idle_pct  = idle;
        stall_pct = stall;
        stop = items_sent + count;
        while (items_sent < stop)
            run_gesture();
    endtask

    initial
    begin : main
        int i;
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // button one across the tick wrap, full scale positions
        send_sample(1'b1, 1'b0, 1'b0, 1'b0, 12'hFFF, 12'hFFF, 32'hFFFF_FFF0);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'h0000_0010);
        send_sample(1'b0, 1'b1, 1'b0, 1'b0, 12'h000, 12'h000, 32'd100);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd200);
        // magic press wins even on a long touch
        send_sample(1'b1, 1'b1, 1'b0, 1'b0, 12'h000, 12'h000, 32'd300);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd2000);
        send_sample(1'b0, 1'b0, 1'b0, 1'b1, 12'hFFF, 12'h000, 32'd5000);
        send_sample(1'b0, 1'b0, 1'b0, 1'b1, 12'h000, 12'h000, 32'd5010);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd5020);
        send_sample(1'b0, 1'b0, 1'b0, 1'b1, 12'h000, 12'h000, 32'd6000);
        send_sample(1'b0, 1'b0, 1'b0, 1'b1, 12'hFFF, 12'h000, 32'd6500);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd7200);
        send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'h000, 32'd8000);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd8010);
        // scroll from bin 9 to bin 0, long release gives no click
        for (i = 0; i < 3; i++)
            send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'hFFF, (i == 0) ? 32'd9000 : 32'd9300);
        for (i = 0; i < 3; i++)
            send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'h000, 32'd9320);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd9350);
        // start inside the dead zone
        for (i = 0; i < 3; i++)
            send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'd1820, 32'd10000 + i * 300);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd10700);
        // zero bin width, then saturation of the bin
        write_reg(CFG_BIN_WIDTH, 16'd0);
        for (i = 0; i < 3; i++)
            send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'd123, 32'd400 * i);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd900);
        write_reg(CFG_BIN_WIDTH, 16'd1);
        for (i = 0; i < 3; i++)
            send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'hFFF, 32'd400 * i);
        for (i = 0; i < 3; i++)
            send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'd7, 32'd900);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd950);
        write_reg(CFG_BIN_WIDTH, 16'(BIN_WIDTH_RST));
        send_sample(1'b0, 1'b0, 1'b1, 1'b0, 12'h000, 12'h000, 32'd500);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 32'd510);

        run_phase(0, 0, 12'd455, 16'd250, 12'd1024, 110);
        run_phase(0, 0, 12'd0, 16'd0, 12'd0, 110);
        run_phase(70, 0, 12'd1, 16'd65535, 12'd4095, 110);
        run_phase(70, 0, 12'd4095, 16'd100, 12'd200, 110);
        run_phase(0, 70, BW_W'($urandom_range(1, 4095)), CT_W'($urandom_range(0, 600)),
                  SD_W'($urandom_range(0, 4095)), 110);
        run_phase(0, 70, 12'd227, 16'd250, 12'd512, 110);
        run_phase(21, 21, BW_W'($urandom_range(1, 900)), CT_W'($urandom_range(0, 65535)),
                  SD_W'($urandom_range(0, 4095)), 110);
        run_phase(21, 21, 12'd455, 16'd40, 12'd1024, 110);

        drain_results();
        repeat (40) @(negedge clk);
        if (sb.mismatches == 0 && sb.expected_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
